>>> hdl/ecdr_pkg.sv
// Shared widths, reset constants and record types for the event cooldown ring.
package ecdr_pkg;

	localparam int unsigned ID_W     = 32;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STAMP_W  = 63;
	localparam int unsigned COOL_W   = 40;
	localparam int unsigned SLOT_W   = 6;

	localparam logic [COOL_W-1:0] COOLDOWN_RESET = 40'd70000000;

	typedef struct packed {
		logic [ID_W-1:0]   caller;
		logic [ID_W-1:0]   target;
		logic [KIND_W-1:0] kind;
	} key_t;

	typedef struct packed {
		key_t               key;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

>>> hdl/ecdr_if.sv
// Valid/ready channel interfaces for event beats and result beats.
interface ecdr_evt_if import ecdr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    caller_id;
	logic [ID_W-1:0]    target_id;
	logic [KIND_W-1:0]  event_kind;
	logic [STAMP_W-1:0] now_stamp;

	modport source (output valid, caller_id, target_id, event_kind, now_stamp, input ready);
	modport sink   (input valid, caller_id, target_id, event_kind, now_stamp, output ready);
endinterface

interface ecdr_res_if import ecdr_pkg::*;;
	logic              valid;
	logic              ready;
	logic              allow;
	logic [SLOT_W-1:0] written_slot;

	modport source (output valid, allow, written_slot, input ready);
	modport sink   (input valid, allow, written_slot, output ready);
endinterface

>>> hdl/ecdr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ecdr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/ecdr_match.sv
// Compare of one stored entry against the incoming event and the cooldown window.
module ecdr_match import ecdr_pkg::*; (
	input  logic               ent_vld,
	input  entry_t             ent,
	input  key_t               key,
	input  logic [STAMP_W-1:0] now,
	input  logic [COOL_W-1:0]  cooldown,
	output logic               hit
);

	logic [STAMP_W-1:0] age;
	logic               occupied;
	logic               same_key;
	logic               not_future;

	assign age        = now - ent.stamp;
	assign occupied   = (ent.stamp != '0);
	assign same_key   = (ent.key == key);
	assign not_future = (now >= ent.stamp);
	assign hit = ent_vld && occupied && same_key && not_future &&
		(age < {{(STAMP_W-COOL_W){1'b0}}, cooldown});

endmodule

>>> hdl/event_cooldown_dedup_ring.sv
// Top level: event deduplication with a cooldown window over a ring of recent events.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------
//  evt      | in  | valid/ready     | caller_id, target_id, event_kind, now_stamp
//  res      | out | valid/ready     | allow, written_slot
//  cfg      | in  | cfg_we (no ack) | cfg_wdata = cooldown_ticks
//
// Each event passes through accept, one ring read per slot through
// the single read port of the entry RAM, a drain state for the read latency,
// and a final state that posts the result and writes the entry back.
// A result waiting in the output register does not block the next event; only
// a second finished result stalls in the write-back state until res is taken.
// Reset clears control state only. Ring slots never written are masked by a
// fill count (slots fill in order from 0), so no clearing pass is needed.
module event_cooldown_dedup_ring import ecdr_pkg::*; #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	ecdr_evt_if.sink          evt,
	ecdr_res_if.source        res,
	input  logic              cfg_we,
	input  logic [COOL_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam int unsigned FW = $clog2(RING_DEPTH + 1);
	localparam int unsigned EW = $bits(entry_t);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]         state_q;
	logic [COOL_W-1:0]  cooldown_q;
	logic [AW-1:0]      scan_idx_q;
	logic [AW-1:0]      next_slot_q;
	logic [FW-1:0]      fill_q;
	logic               hit_q;

	// latched event
	key_t               key_q;
	logic [STAMP_W-1:0] now_q;

	// read pipeline
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;

	// output register
	logic               res_vld_q;
	logic               res_allow_q;
	logic [SLOT_W-1:0]  res_slot_q;

	logic               evt_beat;
	logic               ram_re;
	logic               ram_we;
	logic               fin_go;
	logic [EW-1:0]      ram_rdata;
	entry_t             rd_ent;
	entry_t             wr_ent;
	logic               ent_vld;
	logic               ent_hit;
	logic [AW+SLOT_W-1:0] slot_ext;

	assign evt.ready = (state_q == ST_IDLE);
	assign evt_beat  = evt.valid && evt.ready;

	assign res.valid        = res_vld_q;
	assign res.allow        = res_allow_q;
	assign res.written_slot = res_slot_q;

	// result register is free, or is being emptied this cycle
	assign fin_go  = (state_q == ST_FIN) && (!res_vld_q || res.ready);
	assign ram_re  = (state_q == ST_SCAN);
	assign ram_we  = fin_go && !hit_q;

	assign wr_ent = {key_q, now_q};

	ecdr_ram #(
		.WIDTH(EW),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(next_slot_q),
		.wdata(wr_ent),
		.re   (ram_re),
		.raddr(scan_idx_q),
		.rdata(ram_rdata)
	);

	assign rd_ent  = entry_t'(ram_rdata);
	// slots at or above the fill count were never written and count as empty
	assign ent_vld = rd_vld_s1 && (FW'(rd_idx_s1) < fill_q);

	ecdr_match u_match (
		.ent_vld (ent_vld),
		.ent     (rd_ent),
		.key     (key_q),
		.now     (now_q),
		.cooldown(cooldown_q),
		.hit     (ent_hit)
	);

	// low six bits of the slot, zero-extended for shallow rings
	assign slot_ext = {{SLOT_W{1'b0}}, next_slot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RESET;
		end else if (cfg_we) begin
			cooldown_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_beat) begin
			key_q.caller <= evt.caller_id;
			key_q.target <= evt.target_id;
			key_q.kind   <= evt.event_kind;
			now_q        <= evt.now_stamp;
		end
		rd_idx_s1 <= scan_idx_q;
		if (fin_go) begin
			res_allow_q <= !hit_q;
			res_slot_q  <= hit_q ? '0 : slot_ext[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			next_slot_q <= '0;
			fill_q      <= '0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (ent_hit) begin
				hit_q <= 1'b1;
			end
			// a new result refills the register in the cycle the old one leaves
			if (fin_go) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (evt_beat) begin
						hit_q      <= 1'b0;
						scan_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == AW'(RING_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last read compares this cycle
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (!hit_q) begin
							if (next_slot_q == AW'(RING_DEPTH - 1)) begin
								next_slot_q <= '0;
							end else begin
								next_slot_q <= next_slot_q + 1'b1;
							end
							if (fill_q != FW'(RING_DEPTH)) begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_write_only_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_FIN) && !hit_q && !ram_re)
		else $error("ring write outside write-back or on a suppressed event");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		evt_beat |=> (state_q == ST_SCAN) && (scan_idx_q == '0) && !hit_q)
		else $error("scan did not start from slot zero after accept");

	a_read_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("read data outside scan window");

	a_suppressed_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && hit_q |=> res_vld_q && !res_allow_q && (res_slot_q == '0)
			&& $stable(next_slot_q))
		else $error("suppressed event moved the ring pointer");
`endif

endmodule
